>>> design/crsf_pkg.sv
package crsf_pkg;

    localparam int FLEN_W = 9;
    localparam int IDX_W = 6;
    localparam int CNT_W = 5;
    localparam int BITS_W = 4;
    localparam int HAVE_W = 5;
    localparam int USED_W = 12;
    localparam int ACC_W = 21;

    localparam int NUM_CHANNELS = 16;
    localparam int RESULT_CAP = 16;

    localparam logic [FLEN_W-1:0] HDR_FRAME_LEN = 9'd5;
    localparam logic [FLEN_W-1:0] LEN_POS = 9'd3;
    localparam logic [FLEN_W-1:0] LEN_EXTRA = 9'd2;
    localparam logic [FLEN_W-1:0] FULL_FIRST_BYTE = 9'd3;
    localparam logic [FLEN_W-1:0] SUBSET_FIRST_BYTE = 9'd4;
    localparam logic [BITS_W-1:0] FULL_BITS = 4'd11;
    localparam logic [BITS_W-1:0] SUBSET_BASE_BITS = 4'd10;
    localparam logic [USED_W-1:0] FULL_TOTAL_BITS = 12'd176;
    localparam logic [7:0] CRC_POLY = 8'hD5;

    localparam logic [15:0] GAP_RESET = 16'd1750;
    localparam logic [7:0] ADDR_RESET = 8'd200;
    localparam logic [7:0] FULL_TYPE_RESET = 8'd22;
    localparam logic [7:0] SUBSET_TYPE_RESET = 8'd23;

    localparam logic [1:0] REG_FRAME_GAP = 2'd0;
    localparam logic [1:0] REG_OWN_ADDR = 2'd1;
    localparam logic [1:0] REG_FULL_TYPE = 2'd2;
    localparam logic [1:0] REG_SUBSET_TYPE = 2'd3;

    typedef struct packed {
        logic take;
        logic init;
        logic load;
        logic advance;
    } crsf_cmd_t;

    typedef struct packed {
        logic frame_good;
        logic emit_ok;
        logic need_byte;
    } crsf_sts_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> design/crsf_ram.sv
module crsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/crsf_ctrl.sv
module crsf_ctrl
    import crsf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  crsf_sts_t  sts,
    output crsf_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_READ,
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.take = 1'b1;
                    if (sts.frame_good) begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                cmd.init = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!sts.emit_ok) begin
                    state_next = ST_IDLE;
                end else if (sts.need_byte) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            // ram read data is registered, so it shows up in the cycle after the read
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: begin
                cmd.load = 1'b1;
                state_next = ST_CHECK;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    cmd.advance = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
            m_tvalid_reg <= (state_next == ST_EMIT);
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> design/crsf_dp.sv
module crsf_dp
    import crsf_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  crsf_cmd_t   cmd,
    output crsf_sts_t   sts,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] time_us,
    input  logic [15:0] frame_gap_us,
    input  logic [7:0]  own_address,
    input  logic [7:0]  full_rc_type,
    input  logic [7:0]  subset_rc_type,
    output logic [3:0]  channel_index,
    output logic [12:0] channel_value,
    output logic [3:0]  channel_bits,
    output logic        last_channel
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [FLEN_W-1:0] MAX_FLEN = FLEN_W'(MAX_FRAME_BYTES);

    // framing
    logic [31:0]       start_time_reg;
    logic [PW-1:0]     pos_reg;
    logic [7:0]        addr_reg, len_reg, type_reg, cfg_reg, crc_reg;
    logic [FLEN_W-1:0] flen_reg;

    // unpacking
    logic [ACC_W-1:0]  acc_reg;
    logic [HAVE_W-1:0] have_reg;
    logic [FLEN_W-1:0] rd_reg;
    logic [BITS_W-1:0] bits_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [USED_W-1:0] used_reg, total_reg;

    logic [31:0]       diff;
    logic              restart;
    logic [PW-1:0]     pos_eff;
    logic [FLEN_W-1:0] pos_x, len_plus, flen_cur;
    logic              ignore, complete, wr_en;
    logic [7:0]        ram_rdata, fetch_byte;
    logic              is_full;
    logic [BITS_W-1:0] init_bits;
    logic [12:0]       mask;

    assign diff = time_us - start_time_reg;
    assign restart = !diff[31] && (diff > {16'd0, frame_gap_us});
    assign pos_eff = restart ? '0 : pos_reg;
    assign pos_x = FLEN_W'(pos_eff);
    assign len_plus = {1'b0, len_reg} + LEN_EXTRA;
    assign flen_cur = (pos_x < LEN_POS) ? HDR_FRAME_LEN :
                      ((len_plus > MAX_FLEN) ? MAX_FLEN : len_plus);
    assign ignore = (pos_x >= flen_cur) || (pos_x >= MAX_FLEN);
    assign complete = !ignore && ((pos_x + 9'd1) == flen_cur);
    assign wr_en = cmd.take && !ignore;

    assign sts.frame_good = complete && (crc_reg == rx_byte)
        && ((type_reg == full_rc_type) || (type_reg == subset_rc_type))
        && (addr_reg == own_address);

    crsf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_buf (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (pos_eff[AW-1:0]),
        .wdata (rx_byte),
        .raddr (rd_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_time_reg <= '0;
            pos_reg <= '0;
        end else if (cmd.take) begin
            if (pos_eff == '0) begin
                start_time_reg <= time_us;
            end
            if (ignore) begin
                pos_reg <= pos_eff;
            end else if (complete) begin
                pos_reg <= '0;
            end else begin
                pos_reg <= PW'(pos_x + 9'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (pos_x == 9'd0) addr_reg <= rx_byte;
            if (pos_x == 9'd1) len_reg <= rx_byte;
            if (pos_x == 9'd2) type_reg <= rx_byte;
            if (pos_x == 9'd3) cfg_reg <= rx_byte;
            // running crc from the type byte on; the last byte is compared before update
            crc_reg <= (pos_x < 9'd2) ? 8'd0 : crc8_step(crc_reg, rx_byte);
            if (complete) flen_reg <= flen_cur;
        end
    end

    assign is_full = (type_reg == full_rc_type);
    assign init_bits = is_full ? FULL_BITS : (SUBSET_BASE_BITS + BITS_W'(cfg_reg[6:5]));
    assign fetch_byte = (rd_reg < flen_reg) ? ram_rdata : 8'd0;

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            acc_reg <= '0;
            have_reg <= '0;
            rd_reg <= is_full ? FULL_FIRST_BYTE : SUBSET_FIRST_BYTE;
            bits_reg <= init_bits;
            idx_reg <= is_full ? '0 : IDX_W'(cfg_reg[4:0]);
            cnt_reg <= '0;
            used_reg <= USED_W'(init_bits);
            // subset frames shorter than the header carry no channel bits
            if (is_full) begin
                total_reg <= FULL_TOTAL_BITS;
            end else if (flen_reg < HDR_FRAME_LEN) begin
                total_reg <= '0;
            end else begin
                total_reg <= USED_W'(flen_reg - HDR_FRAME_LEN) << 3;
            end
        end else if (cmd.load) begin
            acc_reg <= acc_reg | (ACC_W'(fetch_byte) << have_reg);
            have_reg <= have_reg + HAVE_W'(8);
            rd_reg <= rd_reg + 9'd1;
        end else if (cmd.advance) begin
            acc_reg <= acc_reg >> bits_reg;
            have_reg <= have_reg - HAVE_W'(bits_reg);
            cnt_reg <= cnt_reg + 5'd1;
            idx_reg <= idx_reg + 6'd1;
            used_reg <= used_reg + USED_W'(bits_reg);
        end
    end

    assign sts.need_byte = (have_reg < HAVE_W'(bits_reg));
    assign sts.emit_ok = (used_reg <= total_reg) && (idx_reg < IDX_W'(NUM_CHANNELS))
        && (cnt_reg < CNT_W'(RESULT_CAP));

    assign mask = 13'h1FFF >> (4'd13 - bits_reg);
    assign channel_index = idx_reg[3:0];
    assign channel_value = acc_reg[12:0] & mask;
    assign channel_bits = bits_reg;
    assign last_channel = ((used_reg + USED_W'(bits_reg)) > total_reg)
        || ((7'(idx_reg) + 7'd1) >= 7'(NUM_CHANNELS))
        || ((cnt_reg + 5'd1) == CNT_W'(RESULT_CAP));

endmodule

>>> design/crsf_rc_frame_receiver.sv
// receives serial link bytes and reports the rc channels of good frames
// input stream: one byte per transaction with its microsecond timestamp;
// framing restarts when a byte comes more than frame_gap_us after frame start
// a byte is taken while s_tready is high; the frame length, crc and
// address/type checks run as the bytes arrive, so a frame is judged on its last byte
// a good rc frame then blocks the input while the channels are unpacked: the
// payload is read back from the frame buffer ram one byte at a time in the steps
// read, load and check, and each channel goes out as one transaction with
// tlast on the final one; the input stays held until the unpacking ends,
// including any output stall
// if the receiver holds m_tready low the unpacker waits on that channel
// reset clears the framing position and frame start time and loads the
// register defaults; the frame buffer is not cleared (every byte read back
// was written in the same frame)
// config registers sit on the apb port at 0x0, 0x4, 0x8, 0xc
module crsf_rc_frame_receiver
    import crsf_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // rx_byte[7:0], time_us[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // channel_index[3:0], channel_value[16:4], channel_bits[20:17]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] gap_reg;
    logic [7:0]  own_reg, full_reg, subset_reg;
    crsf_cmd_t   cmd;
    crsf_sts_t   sts;
    logic [3:0]  ch_index, ch_bits;
    logic [12:0] ch_value;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= GAP_RESET;
            own_reg <= ADDR_RESET;
            full_reg <= FULL_TYPE_RESET;
            subset_reg <= SUBSET_TYPE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_FRAME_GAP:   gap_reg <= pwdata[15:0];
                REG_OWN_ADDR:    own_reg <= pwdata[7:0];
                REG_FULL_TYPE:   full_reg <= pwdata[7:0];
                REG_SUBSET_TYPE: subset_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_GAP:   prdata = {16'd0, gap_reg};
            REG_OWN_ADDR:    prdata = {24'd0, own_reg};
            REG_FULL_TYPE:   prdata = {24'd0, full_reg};
            REG_SUBSET_TYPE: prdata = {24'd0, subset_reg};
            default:         prdata = '0;
        endcase
    end

    crsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    crsf_dp #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .rx_byte        (s_tdata[7:0]),
        .time_us        (s_tdata[39:8]),
        .frame_gap_us   (gap_reg),
        .own_address    (own_reg),
        .full_rc_type   (full_reg),
        .subset_rc_type (subset_reg),
        .channel_index  (ch_index),
        .channel_value  (ch_value),
        .channel_bits   (ch_bits),
        .last_channel   (m_tlast)
    );

    assign m_tdata = {3'd0, ch_bits, ch_value, ch_index};

endmodule
